>>> rtl/core/rhbc_pkg.sv
// ----------------------------------------------------------------------------
// rhbc_pkg
// Shared constants, pipeline stage types and the divider step for the
// byte RGB/HSV converter.
// ----------------------------------------------------------------------------
package rhbc_pkg;

	localparam int BYTE_W    = 8;
	localparam int PROD_W    = 2 * BYTE_W;
	localparam int REGION_W  = 3;
	localparam int NUM_SECTORS = 6;

	// Hue sector width and sector bases on the 0..255 hue circle
	localparam logic [BYTE_W-1:0] HUE_SPAN  = 8'd43;
	localparam logic [BYTE_W-1:0] BASE_RED  = 8'd0;
	localparam logic [BYTE_W-1:0] BASE_GRN  = 8'd85;
	localparam logic [BYTE_W-1:0] BASE_BLU  = 8'd171;
	localparam logic [BYTE_W-1:0] FULL_SCALE = 8'd255;
	localparam logic [BYTE_W-1:0] REM_SCALE = 8'd6;

	// Conversion direction
	localparam logic MODE_TO_HSV = 1'b0;
	localparam logic MODE_TO_RGB = 1'b1;

	// Hue regions for HSV to RGB
	localparam logic [REGION_W-1:0] REG_RED_YEL = 3'd0;
	localparam logic [REGION_W-1:0] REG_YEL_GRN = 3'd1;
	localparam logic [REGION_W-1:0] REG_GRN_CYA = 3'd2;
	localparam logic [REGION_W-1:0] REG_CYA_BLU = 3'd3;
	localparam logic [REGION_W-1:0] REG_BLU_MAG = 3'd4;

	// Restoring divider state: partial remainder, quotient so far and the
	// numerator bits still to be brought down (MSB first).
	typedef struct packed {
		logic [BYTE_W-1:0] rem;
		logic [BYTE_W-1:0] quo;
		logic [BYTE_W-1:0] low_bits;
	} div_t;

	typedef struct packed {
		logic              mode;
		logic [BYTE_W-1:0] alpha;
		logic [BYTE_W-1:0] ch_a;
		logic [BYTE_W-1:0] ch_b;
		logic [BYTE_W-1:0] ch_c;
		// RGB to HSV path
		logic [BYTE_W-1:0] hi;
		logic [BYTE_W-1:0] span;
		logic [BYTE_W-1:0] mag;
		logic              neg;
		logic              black;
		logic              flat;
		logic [BYTE_W-1:0] base;
		div_t              div_sat;
		div_t              div_hue;
		// HSV to RGB path
		logic [REGION_W-1:0] region;
		logic [BYTE_W-1:0]   frac;
		logic [PROD_W-1:0]   prod_p;
		logic [PROD_W-1:0]   prod_q;
		logic [PROD_W-1:0]   prod_t;
		logic [BYTE_W-1:0]   red;
		logic [BYTE_W-1:0]   grn;
		logic [BYTE_W-1:0]   blu;
	} stage_t;

	// One restoring division step. Requires rem < den on entry.
	function automatic div_t div_step(div_t x, logic [BYTE_W-1:0] den);
		logic [BYTE_W:0] trial;
		div_t            y;
		trial = {x.rem, x.low_bits[BYTE_W-1]};
		y.low_bits = {x.low_bits[BYTE_W-2:0], 1'b0};
		if (trial >= {1'b0, den}) begin
			y.rem = BYTE_W'(trial - {1'b0, den});
			y.quo = {x.quo[BYTE_W-2:0], 1'b1};
		end else begin
			y.rem = trial[BYTE_W-1:0];
			y.quo = {x.quo[BYTE_W-2:0], 1'b0};
		end
		return y;
	endfunction

endpackage

>>> rtl/core/rhbc_in_if.sv
// ----------------------------------------------------------------------------
// rhbc_in_if
// Pixel input channel: valid/ready handshake with mode, three channels and
// alpha.
// ----------------------------------------------------------------------------
interface rhbc_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] in_first;
	logic [7:0] in_second;
	logic [7:0] in_third;
	logic [7:0] alpha_in;

	modport source (
		output valid, mode, in_first, in_second, in_third, alpha_in,
		input  ready
	);
	modport sink (
		input  valid, mode, in_first, in_second, in_third, alpha_in,
		output ready
	);
endinterface

>>> rtl/core/rhbc_out_if.sv
// ----------------------------------------------------------------------------
// rhbc_out_if
// Converted pixel channel: valid/ready handshake with three channels and
// alpha.
// ----------------------------------------------------------------------------
interface rhbc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_first;
	logic [7:0] out_second;
	logic [7:0] out_third;
	logic [7:0] alpha_out;

	modport source (
		output valid, out_first, out_second, out_third, alpha_out,
		input  ready
	);
	modport sink (
		input  valid, out_first, out_second, out_third, alpha_out,
		output ready
	);
endinterface

>>> rtl/core/rgb_hsv_byte_converter.sv
// ----------------------------------------------------------------------------
// rgb_hsv_byte_converter
// Byte-precision RGB to HSV and HSV to RGB converter, one pixel per clock while the output is not held off.
// ----------------------------------------------------------------------------
// Takes one pixel per clock when the output is not held off and returns it
// through six pipeline stages plus the output register. The
// depth is set by the two 8-bit restoring dividers for saturation and hue,
// which resolve two quotient bits per stage over four stages; the HSV to RGB
// products travel alongside. Each stage stalls only when it holds a pixel
// and the stage after it cannot take one, so bubbles are squeezed out and a
// new pixel is accepted while a finished one waits on the output.
// ----------------------------------------------------------------------------
module rgb_hsv_byte_converter (
	input  logic        clk,
	input  logic        arst_n,
	rhbc_in_if.sink     pixel,
	rhbc_out_if.source  result
);
	import rhbc_pkg::*;

	stage_t st_s1, st_s2, st_s3, st_s4, st_s5, st_s6;
	stage_t nx_s1, nx_s2, nx_s3, nx_s4, nx_s5, nx_s6;
	logic   vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic   rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_out;
	logic   out_valid_q;
	logic [BYTE_W-1:0] first_nx, second_nx, third_nx;
	logic [BYTE_W-1:0] first_q, second_q, third_q, alpha_q;

	// A stage may load when it is empty or its contents move on
	assign rdy_out = !out_valid_q || result.ready;
	assign rdy_s6  = !vld_s6 || rdy_out;
	assign rdy_s5  = !vld_s5 || rdy_s6;
	assign rdy_s4  = !vld_s4 || rdy_s5;
	assign rdy_s3  = !vld_s3 || rdy_s4;
	assign rdy_s2  = !vld_s2 || rdy_s3;
	assign rdy_s1  = !vld_s1 || rdy_s2;
	assign pixel.ready = rdy_s1;

	// Stage 1: max/min/sector for RGB, region and fraction for HSV
	always_comb begin
		logic [BYTE_W-1:0] r, g, b, hi, lo;
		logic [BYTE_W:0]   diff;
		logic [BYTE_W-1:0] seg;
		r = pixel.in_first;
		g = pixel.in_second;
		b = pixel.in_third;
		nx_s1 = '0;
		nx_s1.mode  = pixel.mode;
		nx_s1.alpha = pixel.alpha_in;
		nx_s1.ch_a  = r;
		nx_s1.ch_b  = g;
		nx_s1.ch_c  = b;

		hi = (r > g) ? r : g;
		hi = (hi > b) ? hi : b;
		lo = (r < g) ? r : g;
		lo = (lo < b) ? lo : b;
		// red wins ties, then green
		priority if (hi == r) begin
			diff = {1'b0, g} - {1'b0, b};
			nx_s1.base = BASE_RED;
		end else if (hi == g) begin
			diff = {1'b0, b} - {1'b0, r};
			nx_s1.base = BASE_GRN;
		end else begin
			diff = {1'b0, r} - {1'b0, g};
			nx_s1.base = BASE_BLU;
		end
		nx_s1.hi    = hi;
		nx_s1.span  = hi - lo;
		nx_s1.neg   = diff[BYTE_W];
		nx_s1.mag   = diff[BYTE_W] ? BYTE_W'(-diff) : diff[BYTE_W-1:0];
		nx_s1.black = (hi == '0);
		nx_s1.flat  = (hi == lo);

		nx_s1.region = '0;
		for (int i = 1; i < NUM_SECTORS; i++) begin
			if ({1'b0, r} >= 9'(HUE_SPAN * i))
				nx_s1.region = REGION_W'(i);
		end
		seg = r - BYTE_W'(HUE_SPAN * nx_s1.region);
		nx_s1.frac = BYTE_W'(seg * REM_SCALE);
	end

	// Stage 2: divider numerators, first HSV products
	always_comb begin
		logic [PROD_W-1:0] num_sat, num_hue;
		nx_s2 = st_s1;
		num_sat = {st_s1.span, {BYTE_W{1'b0}}} - PROD_W'(st_s1.span);
		num_hue = PROD_W'(st_s1.mag) * PROD_W'(HUE_SPAN);
		nx_s2.div_sat = '{rem: num_sat[PROD_W-1:BYTE_W], quo: '0,
			low_bits: num_sat[BYTE_W-1:0]};
		nx_s2.div_hue = '{rem: num_hue[PROD_W-1:BYTE_W], quo: '0,
			low_bits: num_hue[BYTE_W-1:0]};
		nx_s2.prod_p = PROD_W'(st_s1.ch_c) * PROD_W'(FULL_SCALE - st_s1.ch_b);
		nx_s2.prod_q = PROD_W'(st_s1.ch_b) * PROD_W'(st_s1.frac);
		nx_s2.prod_t = PROD_W'(st_s1.ch_b) * PROD_W'(FULL_SCALE - st_s1.frac);
	end

	// Stage 3: quotient bits 7..6, outer q/t products
	always_comb begin
		nx_s3 = st_s2;
		nx_s3.div_sat = div_step(div_step(st_s2.div_sat, st_s2.hi), st_s2.hi);
		nx_s3.div_hue = div_step(div_step(st_s2.div_hue, st_s2.span), st_s2.span);
		nx_s3.prod_q = PROD_W'(st_s2.ch_c) *
			PROD_W'(FULL_SCALE - st_s2.prod_q[PROD_W-1:BYTE_W]);
		nx_s3.prod_t = PROD_W'(st_s2.ch_c) *
			PROD_W'(FULL_SCALE - st_s2.prod_t[PROD_W-1:BYTE_W]);
	end

	// Stage 4: quotient bits 5..4, region routing of v/p/q/t
	always_comb begin
		logic [BYTE_W-1:0] v, p, q, t;
		nx_s4 = st_s3;
		nx_s4.div_sat = div_step(div_step(st_s3.div_sat, st_s3.hi), st_s3.hi);
		nx_s4.div_hue = div_step(div_step(st_s3.div_hue, st_s3.span), st_s3.span);
		v = st_s3.ch_c;
		p = st_s3.prod_p[PROD_W-1:BYTE_W];
		q = st_s3.prod_q[PROD_W-1:BYTE_W];
		t = st_s3.prod_t[PROD_W-1:BYTE_W];
		unique case (st_s3.region)
			REG_RED_YEL: begin
				nx_s4.red = v; nx_s4.grn = t; nx_s4.blu = p;
			end
			REG_YEL_GRN: begin
				nx_s4.red = q; nx_s4.grn = v; nx_s4.blu = p;
			end
			REG_GRN_CYA: begin
				nx_s4.red = p; nx_s4.grn = v; nx_s4.blu = t;
			end
			REG_CYA_BLU: begin
				nx_s4.red = p; nx_s4.grn = q; nx_s4.blu = v;
			end
			REG_BLU_MAG: begin
				nx_s4.red = t; nx_s4.grn = p; nx_s4.blu = v;
			end
			default: begin
				nx_s4.red = v; nx_s4.grn = p; nx_s4.blu = q;
			end
		endcase
	end

	// Stages 5 and 6: remaining quotient bits
	always_comb begin
		nx_s5 = st_s4;
		nx_s5.div_sat = div_step(div_step(st_s4.div_sat, st_s4.hi), st_s4.hi);
		nx_s5.div_hue = div_step(div_step(st_s4.div_hue, st_s4.span), st_s4.span);
	end

	always_comb begin
		nx_s6 = st_s5;
		nx_s6.div_sat = div_step(div_step(st_s5.div_sat, st_s5.hi), st_s5.hi);
		nx_s6.div_hue = div_step(div_step(st_s5.div_hue, st_s5.span), st_s5.span);
	end

	// Output: apply black/grey cases and pick the direction
	always_comb begin
		logic [BYTE_W-1:0] hue_ofs;
		hue_ofs = st_s6.neg ? BYTE_W'(-st_s6.div_hue.quo) : st_s6.div_hue.quo;
		unique case (st_s6.mode)
			MODE_TO_HSV: begin
				first_nx  = (st_s6.black || st_s6.flat) ? '0 : st_s6.base + hue_ofs;
				second_nx = st_s6.black ? '0 : st_s6.div_sat.quo;
				third_nx  = st_s6.hi;
			end
			default: begin
				if (st_s6.ch_b == '0) begin
					first_nx  = st_s6.ch_c;
					second_nx = st_s6.ch_c;
					third_nx  = st_s6.ch_c;
				end else begin
					first_nx  = st_s6.red;
					second_nx = st_s6.grn;
					third_nx  = st_s6.blu;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			vld_s5      <= 1'b0;
			vld_s6      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1)  vld_s1      <= pixel.valid;
			if (rdy_s2)  vld_s2      <= vld_s1;
			if (rdy_s3)  vld_s3      <= vld_s2;
			if (rdy_s4)  vld_s4      <= vld_s3;
			if (rdy_s5)  vld_s5      <= vld_s4;
			if (rdy_s6)  vld_s6      <= vld_s5;
			if (rdy_out) out_valid_q <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && pixel.valid) st_s1 <= nx_s1;
		if (rdy_s2 && vld_s1)      st_s2 <= nx_s2;
		if (rdy_s3 && vld_s2)      st_s3 <= nx_s3;
		if (rdy_s4 && vld_s3)      st_s4 <= nx_s4;
		if (rdy_s5 && vld_s4)      st_s5 <= nx_s5;
		if (rdy_s6 && vld_s5)      st_s6 <= nx_s6;
		if (rdy_out && vld_s6) begin
			first_q  <= first_nx;
			second_q <= second_nx;
			third_q  <= third_nx;
			alpha_q  <= st_s6.alpha;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.out_first  = first_q;
	assign result.out_second = second_q;
	assign result.out_third  = third_q;
	assign result.alpha_out  = alpha_q;

endmodule
